// ===== hdl/itda_pkg.sv =====
package itda_pkg;

   // Fixed field widths
   localparam int VALUE_W  = 32;
   localparam int DIGITS_W = 5;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 5;

   // Ten BCD digits cover any 32-bit magnitude
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);

   // Pad count never exceeds this, so the text fits in 17 characters
   localparam int PAD_HARD_LIMIT = 16;

   // Request queue depth between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // One classified request
   typedef struct packed {
      logic [VALUE_W-1:0]  magnitude;
      logic [DIGITS_W-1:0] pad_to;
      logic                minus;
   } entry_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

// ===== hdl/itda_front.sv =====
module itda_front #(
   parameter int MAX_PAD = 16
) (
   input  logic signed [itda_pkg::VALUE_W-1:0]  value,
   input  logic        [itda_pkg::DIGITS_W-1:0] min_digits,
   input  logic                                 sign_enable,
   output itda_pkg::entry_type                  entry
);

   localparam int PadLimit = (MAX_PAD < itda_pkg::PAD_HARD_LIMIT) ?
                             MAX_PAD : itda_pkg::PAD_HARD_LIMIT;
   localparam logic [itda_pkg::DIGITS_W-1:0] PadCap = itda_pkg::DIGITS_W'(PadLimit);

   logic                              negative;
   logic [itda_pkg::VALUE_W-1:0]      magnitude;
   logic                              is_zero;
   logic [itda_pkg::DIGITS_W-1:0]     pad_clamped;

   // Unsigned magnitude, so the most negative value converts too
   assign negative  = value[itda_pkg::VALUE_W-1];
   assign magnitude = negative ? (~value + 1'b1) : value;
   assign is_zero   = (magnitude == '0);

   // Clamp requested width
   assign pad_clamped = (min_digits > PadCap) ? PadCap : min_digits;

   // Zero never gets padding or a sign
   always_comb begin
      entry.magnitude = magnitude;
      entry.pad_to    = is_zero ? '0 : pad_clamped;
      entry.minus     = sign_enable & negative & ~is_zero;
   end

endmodule

// ===== hdl/itda_queue.sv =====
module itda_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  itda_pkg::entry_type     push_entry,
   input  logic                    pop,
   output logic                    full,
   output itda_pkg::queue_head_type head
);

   itda_pkg::entry_type                 mem [itda_pkg::QUEUE_DEPTH];
   logic [itda_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [itda_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [itda_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                do_push, do_pop;

   assign full    = (count_ff == itda_pkg::QUEUE_CNT_W'(itda_pkg::QUEUE_DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = mem[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/itda_back.sv =====
module itda_back (
   input  logic                           clock,
   input  logic                           reset,
   input  itda_pkg::queue_head_type       head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [itda_pkg::CHAR_W-1:0]    rsp_character,
   output logic                           rsp_last,
   output logic [itda_pkg::LEN_W-1:0]     rsp_text_length
);

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      SIZE,
      EMIT
   } state_type;

   localparam int StepW = $clog2(itda_pkg::VALUE_W);

   state_type                         state_ff, state_in;
   logic [itda_pkg::VALUE_W-1:0]      shift_ff, shift_in;
   logic [itda_pkg::BCD_W-1:0]        bcd_ff, bcd_in;
   logic [StepW-1:0]                  step_ff, step_in;
   logic [itda_pkg::DIGITS_W-1:0]     pad_ff, pad_in;
   logic                              minus_ff, minus_in;
   logic [itda_pkg::DIG_IDX_W-1:0]    dig_idx_ff, dig_idx_in;
   logic [itda_pkg::LEN_W-1:0]        remain_ff, remain_in;
   logic [itda_pkg::LEN_W-1:0]        len_ff, len_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [itda_pkg::CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [itda_pkg::LEN_W-1:0]        rsp_len_ff, rsp_len_in;

   logic [itda_pkg::BCD_W-1:0]        bcd_adj;
   logic [itda_pkg::DIG_IDX_W:0]      num_digits;
   logic [itda_pkg::DIGITS_W-1:0]     num_digits_w;
   logic [3:0]                        cur_digit;
   logic                              slot_free;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign cur_digit = bcd_ff[{dig_idx_ff, 2'b00} +: 4];
   assign pop       = (state_ff == IDLE) & head.valid;

   // Double-dabble correction: add 3 to every digit of 5 or more
   always_comb begin
      for (int i = 0; i < itda_pkg::BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // Significant digit count, at least one
   always_comb begin
      num_digits = (itda_pkg::DIG_IDX_W + 1)'(1);
      for (int i = 0; i < itda_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            num_digits = (itda_pkg::DIG_IDX_W + 1)'(i + 1);
         end
      end
      num_digits_w = itda_pkg::DIGITS_W'(num_digits);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      pad_in       = pad_ff;
      minus_in     = minus_ff;
      dig_idx_in   = dig_idx_ff;
      remain_in    = remain_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;

      unique case (state_ff)
         IDLE: begin
            if (head.valid) begin
               shift_in = head.entry.magnitude;
               bcd_in   = '0;
               step_in  = '0;
               pad_in   = head.entry.pad_to;
               minus_in = head.entry.minus;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            bcd_in   = {bcd_adj[itda_pkg::BCD_W-2:0], shift_ff[itda_pkg::VALUE_W-1]};
            shift_in = {shift_ff[itda_pkg::VALUE_W-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == StepW'(itda_pkg::VALUE_W - 1)) begin
               state_in = SIZE;
            end
         end
         SIZE: begin
            // pad_ff turns from target width into leading zero count
            if (pad_ff > num_digits_w) begin
               pad_in = pad_ff - num_digits_w;
               len_in = itda_pkg::LEN_W'(minus_ff) + itda_pkg::LEN_W'(pad_ff);
            end else begin
               pad_in = '0;
               len_in = itda_pkg::LEN_W'(minus_ff) + itda_pkg::LEN_W'(num_digits_w);
            end
            remain_in  = len_in;
            dig_idx_in = itda_pkg::DIG_IDX_W'(num_digits - 1'b1);
            state_in   = EMIT;
         end
         EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = len_ff;
               rsp_last_in  = (remain_ff == itda_pkg::LEN_W'(1));
               remain_in    = remain_ff - 1'b1;
               if (minus_ff) begin
                  rsp_char_in = itda_pkg::CHAR_MINUS;
                  minus_in    = 1'b0;
               end else if (pad_ff != '0) begin
                  rsp_char_in = itda_pkg::CHAR_ZERO;
                  pad_in      = pad_ff - 1'b1;
               end else begin
                  rsp_char_in = itda_pkg::CHAR_ZERO | {4'd0, cur_digit};
                  dig_idx_in  = dig_idx_ff - 1'b1;
               end
               if (remain_ff == itda_pkg::LEN_W'(1)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      pad_ff      <= pad_in;
      minus_ff    <= minus_in;
      dig_idx_ff  <= dig_idx_in;
      remain_ff   <= remain_in;
      len_ff      <= len_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_character   = rsp_char_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_text_length = rsp_len_ff;

endmodule

// ===== hdl/int_to_decimal_ascii_top.sv =====
// A request passes the queue, 32 double-dabble steps in the back end, sizing
// and the output register before its first character is valid. The back end
// converts one request at a time in its bit-serial binary to BCD loop while
// the queue holds more; characters stream at one per cycle unless stalled.
// Reset (synchronous, active high) empties the request queue and the output.
module int_to_decimal_ascii_top #(
   parameter int MAX_PAD = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [itda_pkg::VALUE_W-1:0]  req_value,
   input  logic        [itda_pkg::DIGITS_W-1:0] req_min_digits,
   input  logic                                 req_sign_enable,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [itda_pkg::CHAR_W-1:0]   rsp_character,
   output logic                                 rsp_last,
   output logic        [itda_pkg::LEN_W-1:0]    rsp_text_length
);

   itda_pkg::entry_type      front_entry;
   itda_pkg::queue_head_type head;
   logic                     queue_full;
   logic                     pop;

   // Classify the request
   itda_front #(
      .MAX_PAD (MAX_PAD)
   ) u_front (
      .value       (req_value),
      .min_digits  (req_min_digits),
      .sign_enable (req_sign_enable),
      .entry       (front_entry)
   );

   // Decouple front from back
   itda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .pop        (pop),
      .full       (queue_full),
      .head       (head)
   );

   assign req_stall = queue_full;

   // Convert and stream characters
   itda_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length)
   );

   // A text keeps streaming with a steady length until its last character
   a_stream_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && $stable(rsp_text_length))
      else $error("character stream broke before the last character");

   // Length stays within the padded limit
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_length != '0) && (rsp_text_length <= 5'd17))
      else $error("text length out of range");

   // A minus sign never ends a text
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == itda_pkg::CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked as last character");

endmodule

// ===== tb/int_to_decimal_ascii_top_tb.sv =====
`timescale 1ns / 100ps

module int_to_decimal_ascii_top_tb;

   localparam int MAX_PAD    = 16;
   localparam int PAD_CAP    = (MAX_PAD < itda_pkg::PAD_HARD_LIMIT) ?
                               MAX_PAD : itda_pkg::PAD_HARD_LIMIT;
   localparam int LONG_HOLD  = 500;
   localparam int END_WAIT   = 80;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_COUNT = 200;

   // One character of the expected text
   typedef struct {
      logic [itda_pkg::CHAR_W-1:0] character;
      logic                        last;
      logic [itda_pkg::LEN_W-1:0]  text_length;
   } text_char_type;

   // Expected text per request and per-character compare
   class decimal_text_scoreboard;
      text_char_type expected_chars[$];
      int            pad_cap;
      int            numbers_taken;
      int            chars_checked;
      int            longest_text;
      int            mismatch_count;

      function new(int cap);
         pad_cap        = cap;
         numbers_taken  = 0;
         chars_checked  = 0;
         longest_text   = 0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // Build the decimal text of an accepted request
      function void note_request(logic [itda_pkg::VALUE_W-1:0] value,
                                 logic [itda_pkg::DIGITS_W-1:0] min_digits,
                                 logic sign_enable);
         logic [itda_pkg::VALUE_W-1:0] magnitude;
         logic [itda_pkg::CHAR_W-1:0]  text[$];
         logic [itda_pkg::CHAR_W-1:0]  digit;
         int                           pad_to;
         text_char_type                one_char;
         magnitude = value[itda_pkg::VALUE_W-1] ? (32'd0 - value) : value;
         pad_to = (int'(min_digits) > pad_cap) ? pad_cap : int'(min_digits);
         if (magnitude == 0) begin
            // zero ignores padding and sign
            text.push_back(itda_pkg::CHAR_ZERO);
         end else begin
            while (magnitude != 0) begin
               digit = itda_pkg::CHAR_ZERO + 8'(magnitude % 10);
               text.push_front(digit);
               magnitude = magnitude / 10;
            end
            while (text.size() < pad_to)
               text.push_front(itda_pkg::CHAR_ZERO);
            if (sign_enable && value[itda_pkg::VALUE_W-1])
               text.push_front(itda_pkg::CHAR_MINUS);
         end
         foreach (text[k]) begin
            one_char.character   = text[k];
            one_char.last        = (k == text.size() - 1);
            one_char.text_length = itda_pkg::LEN_W'(text.size());
            expected_chars.push_back(one_char);
         end
         numbers_taken++;
         if (text.size() > longest_text)
            longest_text = text.size();
      endfunction

      function void check_char(logic [itda_pkg::CHAR_W-1:0] character, logic last,
                               logic [itda_pkg::LEN_W-1:0] text_length);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected character %h last %b length %0d",
                        $realtime, character, last, text_length);
            return;
         end
         want = expected_chars.pop_front();
         chars_checked++;
         if (character !== want.character || last !== want.last ||
             text_length !== want.text_length) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: mismatch char %h/%h last %b/%b length %0d/%0d (exp/got)",
                        $realtime, want.character, character, want.last, last,
                        want.text_length, text_length);
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [itda_pkg::VALUE_W-1:0]  req_value;
   logic [itda_pkg::DIGITS_W-1:0]        req_min_digits;
   logic                                 req_sign_enable;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [itda_pkg::CHAR_W-1:0]          rsp_character;
   logic                                 rsp_last;
   logic [itda_pkg::LEN_W-1:0]           rsp_text_length;

   logic                                 hold_request;
   int                                   stall_pct;
   int                                   cycle_count = 0;

   decimal_text_scoreboard text_board = new(PAD_CAP);

   int_to_decimal_ascii_top #(
      .MAX_PAD (MAX_PAD)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_min_digits  (req_min_digits),
      .req_sign_enable (req_sign_enable),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d characters still expected", text_board.pending());
         $display("int_to_decimal_ascii_top_tb: done, errors");
         $finish;
      end
   end

   // Check every character taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         text_board.check_char(rsp_character, rsp_last, rsp_text_length);
   end

   // Receiver stall pattern, with an occasional long hold-off
   // (a toggle of hold_request starts one hold-off)
   initial begin
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Present one request and hold it until taken
   task automatic send_number(input logic [itda_pkg::VALUE_W-1:0] value,
                              input logic [itda_pkg::DIGITS_W-1:0] min_digits,
                              input logic sign_enable);
      req_valid       <= 1'b1;
      req_value       <= value;
      req_min_digits  <= min_digits;
      req_sign_enable <= sign_enable;
      do @(posedge clock); while (req_stall);
      text_board.note_request(value, min_digits, sign_enable);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (text_board.pending() != 0);
   endtask

   // Mix of small, boundary, power-of-ten and full-range values
   function automatic logic [itda_pkg::VALUE_W-1:0] random_value();
      logic [itda_pkg::VALUE_W-1:0] v;
      int                           exponent;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 99);
         1: v = $urandom_range(0, 99999);
         2: v = $urandom;
         3: begin
            exponent = $urandom_range(0, 9);
            v = 1;
            repeat (exponent) v = v * 10;
            v = v + $urandom_range(0, 2) - 1;
         end
         4: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               default: v = 32'h0000_0001;
            endcase
         end
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1))
         v = 32'd0 - v;
      return v;
   endfunction

   function automatic logic [itda_pkg::DIGITS_W-1:0] random_min_digits();
      if ($urandom_range(0, 3) == 0)
         return itda_pkg::DIGITS_W'($urandom_range(0, 31));
      return itda_pkg::DIGITS_W'($urandom_range(0, 16));
   endfunction

   // Random requests in bursts with random gaps
   task automatic random_numbers(input int count);
      int burst_left;
      burst_left = $urandom_range(1, 12);
      repeat (count) begin
         send_number(random_value(), random_min_digits(), 1'($urandom_range(0, 1)));
         burst_left--;
         if (burst_left == 0) begin
            idle_sender($urandom_range(1, 40));
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      req_valid       <= 1'b0;
      req_value       <= '0;
      req_min_digits  <= '0;
      req_sign_enable <= 1'b0;
      hold_request    <= 1'b0;
      stall_pct       <= 0;
      reset           <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, extremes, padding around the cap, sign on and off
      send_number(32'd0, 5'd16, 1'b1);
      send_number(32'd0, 5'd0, 1'b0);
      send_number(32'h8000_0000, 5'd0, 1'b1);
      send_number(32'h8000_0000, 5'd16, 1'b0);
      send_number(32'h8000_0000, 5'd31, 1'b1);
      send_number(32'h7FFF_FFFF, 5'd0, 1'b1);
      send_number(32'h7FFF_FFFF, 5'd16, 1'b0);
      send_number(32'hFFFF_FFFF, 5'd16, 1'b1);
      send_number(32'hFFFF_FFFF, 5'd0, 1'b0);
      send_number(32'd1, 5'd31, 1'b1);
      send_number(32'd1, 5'd17, 1'b0);
      send_number(32'd1, 5'd1, 1'b1);
      send_number(32'd12345, 5'd3, 1'b1);
      send_number(32'd12345, 5'd5, 1'b0);
      send_number(32'd12345, 5'd6, 1'b1);
      send_number(-32'sd12345, 5'd0, 1'b0);
      send_number(-32'sd12345, 5'd8, 1'b1);
      send_number(32'd1000000000, 5'd10, 1'b0);
      send_number(-32'sd999999999, 5'd12, 1'b1);
      send_number(32'd9, 5'd2, 1'b0);
      send_number(32'd10, 5'd0, 1'b1);
      send_number(32'h5555_5555, 5'd10, 1'b1);
      send_number(32'hAAAA_AAAA, 5'd21, 1'b1);
      wait_drained();

      // Moderate receiver stalls
      stall_pct <= 25;
      random_numbers(RANDOM_COUNT / 4);
      wait_drained();

      // Long hold-off while requests keep coming back to back
      hold_request <= ~hold_request;
      repeat (12) send_number(random_value(), random_min_digits(), 1'($urandom_range(0, 1)));
      wait_drained();

      // No receiver stalls, then heavy ones, then light ones
      stall_pct <= 0;
      random_numbers(RANDOM_COUNT / 4);
      stall_pct <= 60;
      random_numbers(RANDOM_COUNT / 4);
      stall_pct <= 10;
      random_numbers(RANDOM_COUNT / 4);

      wait_drained();
      repeat (END_WAIT) @(posedge clock);

      $display("%0d numbers converted, %0d characters compared, longest text %0d chars",
               text_board.numbers_taken, text_board.chars_checked, text_board.longest_text);
      $display("%0d mismatches", text_board.mismatch_count);
      if (text_board.mismatch_count == 0) begin
         $display("int_to_decimal_ascii_top_tb: done, clean");
      end else begin
         $display("int_to_decimal_ascii_top_tb: done, errors");
      end
      $finish;
   end

endmodule
